// ===== src/line_position_centroid_macros.svh =====
// ----------------------------------------------------------------------------
// line_position_centroid_macros
// Assertion macros shared by the checker of the line position block.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_CENTROID_MACROS_SVH
`define LINE_POSITION_CENTROID_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define LPC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("lpc assertion failed");

// Clocked assertion that also holds across reset.
`define LPC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("lpc reset assertion failed");

`endif

// ===== src/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and constants of the line position centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

    localparam int MAX_CH      = 8;
    localparam int READING_W   = 16;
    localparam int WEIGHT_W    = 8;
    localparam int COUNT_W     = 4;
    localparam int ERR_W       = 12;
    localparam int Q_BITS      = 12;
    localparam int FRAC_SHIFT  = 4;
    localparam int IN_W        = MAX_CH * READING_W;
    localparam int OUT_W       = 24;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 5;
    localparam int REG_LSB     = 3;
    localparam int ERR_MAX     = 2047;

    typedef enum logic [1:0] {
        REG_WHITE_LO  = 2'd0,
        REG_WHITE_HI  = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_WEIGHTS   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MAX_CH-1:0][READING_W-1:0] white;
        logic [READING_W-1:0]             thr;
        logic [MAX_CH-1:0][WEIGHT_W-1:0]  weight;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/line_position_centroid.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid
// Weighted-centroid line position from a bank of reflective sensor channels.
// ----------------------------------------------------------------------------
// One transfer in carries a reading of every channel; one transfer out gives
// the active channel count, the lateral error in signed Q8.4 and a lost flag.
// The block takes one transfer per cycle while the output side is not
// stalled. Each result passes through the strength, weighting and summation
// registers, a register that takes the magnitude, the restoring divider that
// settles one quotient bit per stage, and the output register. Registers are
// written over APB at byte addresses 0, 8, 16 and 24.
`default_nettype none

module line_position_centroid
    import lpc_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // reading_ch0 .. reading_ch7, 16 bits each
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // chan_count[3:0], line_offset[15:4], line_lost[16], zero pad
    output logic [OUT_W-1:0]       m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int PW  = SAMPLE_BITS + WEIGHT_W;
    localparam int WSW = PW + $clog2(CHANNELS);
    localparam int SSW = SAMPLE_BITS + $clog2(CHANNELS);

    cfg_t                    cfg;
    logic                    f_valid;
    logic                    f_ready;
    logic [COUNT_W-1:0]      f_count;
    logic signed [WSW-1:0]   f_wsum;
    logic [SSW-1:0]          f_ssum;
    logic [COUNT_W-1:0]      m_count;
    logic signed [ERR_W-1:0] m_err;
    logic                    m_lost;

    lpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpc_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_count  (f_count),
        .f_wsum   (f_wsum),
        .f_ssum   (f_ssum)
    );

    lpc_div #(
        .WSW (WSW),
        .SSW (SSW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_count  (f_count),
        .f_wsum   (f_wsum),
        .f_ssum   (f_ssum),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_count  (m_count),
        .m_err    (m_err),
        .m_lost   (m_lost)
    );

    assign m_tdata = {(OUT_W - COUNT_W - ERR_W - 1)'(0), m_lost, m_err, m_count};

endmodule

`default_nettype wire

// ===== src/lpc_cfg.sv =====
// ----------------------------------------------------------------------------
// lpc_cfg
// APB register file: white references, strength threshold, channel weights.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_cfg
    import lpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [APB_DW-1:0]    white_lo_reg;
    logic [APB_DW-1:0]    white_hi_reg;
    logic [READING_W-1:0] thr_reg;
    logic [APB_DW-1:0]    weights_reg;
    reg_idx_t             idx;
    logic                 wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_lo_reg <= '0;
            white_hi_reg <= '0;
            thr_reg      <= '0;
            weights_reg  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_WHITE_LO:  white_lo_reg <= pwdata;
                REG_WHITE_HI:  white_hi_reg <= pwdata;
                REG_THRESHOLD: thr_reg      <= pwdata[READING_W-1:0];
                REG_WEIGHTS:   weights_reg  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WHITE_LO:  prdata = white_lo_reg;
            REG_WHITE_HI:  prdata = white_hi_reg;
            REG_THRESHOLD: prdata = APB_DW'(thr_reg);
            REG_WEIGHTS:   prdata = weights_reg;
        endcase
    end

    assign cfg.white  = {white_hi_reg, white_lo_reg};
    assign cfg.thr    = thr_reg;
    assign cfg.weight = weights_reg;

endmodule

`default_nettype wire

// ===== src/lpc_front.sv =====
// ----------------------------------------------------------------------------
// lpc_front
// Strength, product and sum stages: per-channel black strength, weighted
// products, and the weighted and plain strength sums with active count.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_front
    import lpc_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int PW          = SAMPLE_BITS + WEIGHT_W,
    parameter int WSW         = PW + $clog2(CHANNELS),
    parameter int SSW         = SAMPLE_BITS + $clog2(CHANNELS)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,
    input  wire cfg_t                  cfg,
    output logic                       f_valid,
    input  wire logic                  f_ready,
    output logic [COUNT_W-1:0]         f_count,
    output logic signed [WSW-1:0]      f_wsum,
    output logic [SSW-1:0]             f_ssum
);

    logic [2:0] v_reg;
    logic [2:0] adv;

    logic [SAMPLE_BITS-1:0] a_str_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] a_str_next [CHANNELS];
    logic [CHANNELS-1:0]    a_act_reg;
    logic [CHANNELS-1:0]    a_act_next;

    logic signed [PW-1:0]   b_prod_reg  [CHANNELS];
    logic signed [PW-1:0]   b_prod_next [CHANNELS];
    logic [SAMPLE_BITS-1:0] b_str_reg   [CHANNELS];
    logic [CHANNELS-1:0]    b_act_reg;

    logic signed [WSW-1:0]  c_wsum_reg;
    logic signed [WSW-1:0]  c_wsum_next;
    logic [SSW-1:0]         c_ssum_reg;
    logic [SSW-1:0]         c_ssum_next;
    logic [COUNT_W-1:0]     c_count_reg;
    logic [COUNT_W-1:0]     c_count_next;

    assign adv[2]   = !v_reg[2] || f_ready;
    assign adv[1]   = !v_reg[1] || adv[2];
    assign adv[0]   = !v_reg[0] || adv[1];
    assign s_tready = adv[0];

    // strength = white - reading, clamped at zero; keep only active channels
    always_comb begin
        logic [SAMPLE_BITS-1:0] rd;
        logic [SAMPLE_BITS-1:0] wr;
        logic [SAMPLE_BITS-1:0] str;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            rd  = s_tdata[ch*READING_W +: SAMPLE_BITS];
            wr  = cfg.white[ch][SAMPLE_BITS-1:0];
            str = (wr > rd) ? (wr - rd) : '0;
            a_act_next[ch] = READING_W'(str) > cfg.thr;
            a_str_next[ch] = a_act_next[ch] ? str : '0;
        end
    end

    always_comb begin
        logic signed [WEIGHT_W-1:0] w;
        logic signed [PW-1:0]       ext_s;
        logic signed [PW-1:0]       ext_w;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            w     = cfg.weight[ch];
            ext_s = PW'(signed'({1'b0, a_str_reg[ch]}));
            ext_w = PW'(w);
            b_prod_next[ch] = ext_s * ext_w;
        end
    end

    always_comb begin
        c_wsum_next  = '0;
        c_ssum_next  = '0;
        c_count_next = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            c_wsum_next  = c_wsum_next + WSW'(b_prod_reg[ch]);
            c_ssum_next  = c_ssum_next + SSW'(b_str_reg[ch]);
            c_count_next = c_count_next + COUNT_W'(b_act_reg[ch]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= s_tvalid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a_str_reg <= a_str_next;
            a_act_reg <= a_act_next;
        end
        if (adv[1]) begin
            b_prod_reg <= b_prod_next;
            b_str_reg  <= a_str_reg;
            b_act_reg  <= a_act_reg;
        end
        if (adv[2]) begin
            c_wsum_reg  <= c_wsum_next;
            c_ssum_reg  <= c_ssum_next;
            c_count_reg <= c_count_next;
        end
    end

    assign f_valid = v_reg[2];
    assign f_count = c_count_reg;
    assign f_wsum  = c_wsum_reg;
    assign f_ssum  = c_ssum_reg;

endmodule

`default_nettype wire

// ===== src/lpc_div.sv =====
// ----------------------------------------------------------------------------
// lpc_div
// Pipelined restoring divider: one quotient bit per stage, sign restore,
// saturation of positive quotients and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_div
    import lpc_pkg::*;
#(
    parameter int WSW = 27,
    parameter int SSW = 19,
    parameter int RW  = WSW + FRAC_SHIFT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 f_valid,
    output logic                      f_ready,
    input  wire logic [COUNT_W-1:0]   f_count,
    input  wire logic signed [WSW-1:0] f_wsum,
    input  wire logic [SSW-1:0]       f_ssum,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [COUNT_W-1:0]        m_count,
    output logic signed [ERR_W-1:0]   m_err,
    output logic                      m_lost
);

    typedef struct packed {
        logic [RW-1:0]      rem;
        logic [SSW-1:0]     den;
        logic [Q_BITS-1:0]  q;
        logic               neg;
        logic [COUNT_W-1:0] count;
    } div_t;

    div_t st_reg  [Q_BITS+1];
    div_t st_next [Q_BITS+1];

    logic [Q_BITS+1:0] v_reg;
    logic [Q_BITS+1:0] adv;

    logic [COUNT_W-1:0]      out_count_reg;
    logic signed [ERR_W-1:0] out_err_reg;
    logic signed [ERR_W-1:0] out_err_next;
    logic                    out_lost_reg;

    always_comb begin
        adv[Q_BITS+1] = !v_reg[Q_BITS+1] || m_tready;
        for (int i = Q_BITS; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign f_ready = adv[0];

    always_comb begin
        logic [WSW-1:0] mag;
        logic [RW-1:0]  trial;
        st_next[0].neg   = f_wsum < 0;
        mag              = st_next[0].neg ? WSW'(-f_wsum) : WSW'(f_wsum);
        st_next[0].rem   = RW'(mag) << FRAC_SHIFT;
        st_next[0].den   = f_ssum;
        st_next[0].q     = '0;
        st_next[0].count = f_count;
        for (int i = 1; i <= Q_BITS; i++) begin
            st_next[i] = st_reg[i-1];
            trial      = RW'(st_reg[i-1].den) << (Q_BITS - i);
            if (st_reg[i-1].rem >= trial) begin
                st_next[i].rem           = st_reg[i-1].rem - trial;
                st_next[i].q[Q_BITS - i] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [Q_BITS:0] qx;
        qx = {1'b0, st_reg[Q_BITS].q};
        if (st_reg[Q_BITS].count == '0) begin
            out_err_next = '0;
        end else if (st_reg[Q_BITS].neg) begin
            out_err_next = ERR_W'(-qx);
        end else if (qx > (Q_BITS+1)'(ERR_MAX)) begin
            out_err_next = ERR_W'(ERR_MAX);
        end else begin
            out_err_next = ERR_W'(qx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= f_valid;
            for (int i = 1; i <= Q_BITS + 1; i++) begin
                if (adv[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i <= Q_BITS; i++) begin
            if (adv[i]) st_reg[i] <= st_next[i];
        end
        if (adv[Q_BITS+1]) begin
            out_count_reg <= st_reg[Q_BITS].count;
            out_err_reg   <= out_err_next;
            out_lost_reg  <= (st_reg[Q_BITS].count == '0);
        end
    end

    assign m_tvalid = v_reg[Q_BITS+1];
    assign m_count  = out_count_reg;
    assign m_err    = out_err_reg;
    assign m_lost   = out_lost_reg;

endmodule

`default_nettype wire

// ===== src/lpc_checker.sv =====
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks of the line position block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_position_centroid_macros.svh"

module lpc_checker
    import lpc_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata
);

    logic [COUNT_W-1:0] count;
    logic [ERR_W-1:0]   err;
    logic               lost;

    assign count = m_tdata[COUNT_W-1:0];
    assign err   = m_tdata[COUNT_W +: ERR_W];
    assign lost  = m_tdata[COUNT_W + ERR_W];

    `LPC_ASSERT(a_lost_matches_count, m_tvalid |-> (lost == (count == '0)))
    `LPC_ASSERT(a_lost_zero_error, (m_tvalid && lost) |-> (err == '0))
    `LPC_ASSERT(a_count_in_range, m_tvalid |-> (count <= COUNT_W'(MAX_CH)))
    `LPC_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    `LPC_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid)

endmodule

bind line_position_centroid lpc_checker u_lpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
